// ----- sv/lsf_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the line fit.
package lsf_pkg;

  localparam int MAX_POINTS      = 1024;
  localparam int COORD_WIDTH     = 20;
  localparam int COORD_FRAC_BITS = 8;

  localparam int LOG_MAX  = $clog2(MAX_POINTS);
  localparam int CNT_W    = $clog2(MAX_POINTS + 1);
  localparam int SUM_W    = COORD_WIDTH + LOG_MAX;
  localparam int SQ_W     = 2 * COORD_WIDTH + LOG_MAX;
  localparam int OPW      = SQ_W;
  localparam int PW       = 2 * OPW;
  localparam int NUM_W    = PW + 18;
  localparam int ITER_W   = $clog2(NUM_W + 1);
  localparam int RES_W    = 32;
  localparam int SLOPE_SH = 16;
  localparam int OFF_SH   = 16 - COORD_FRAC_BITS;

  typedef enum logic [2:0] {
    TERM_DET,
    TERM_SLOPE_X,
    TERM_OFFSET_X,
    TERM_SLOPE_Y,
    TERM_OFFSET_Y
  } term_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_MLOAD,
    ST_MRUN,
    ST_MDONE,
    ST_DCHK,
    ST_DLOAD,
    ST_DRUN,
    ST_DSTORE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  accept;
    logic  mul_load;
    logic  mul_step;
    logic  mul_done;
    logic  div_load;
    logic  div_step;
    logic  div_store;
    logic  load_out;
    term_t term;
    logic  half;
  } cmd_t;

  typedef struct packed {
    logic d_zero;
  } sts_t;

endpackage

// ----- sv/least_squares_3d_line_fit.sv -----
// Top level of the least-squares 3D line fit: stream ports, controller and datapath.
// Points are taken one per clock while a set is being accumulated. The point
// marked last starts the solve, during which no point is taken: a drain state
// finishes the pending add, then ten products on a shared shift-add multiplier
// (OPW = 50) and four quotients on a restoring divider (NUM_W = 118); a zero
// determinant ends the solve after the determinant product.
// The result waits in an output register, so a new set may start while it is
// still held.
module least_squares_3d_line_fit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // x_coord[19:0], y_coord[39:20], z_coord[59:40], zero fill
  input  logic         s_tlast,   // last_point
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // slope_x, offset_x, slope_y, offset_y, points_used, zero fill
  output logic [1:0]   m_tuser    // degenerate, overflowed
);
  import lsf_pkg::*;

  cmd_t                    cmd;
  sts_t                    sts;
  logic signed [RES_W-1:0] slope_x, offset_x, slope_y, offset_y;
  logic                    degenerate, overflowed;
  logic [CNT_W-1:0]        points_used;

  lsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .m_tready (m_tready),
    .sts      (sts),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  lsf_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .x_coord     ($signed(s_tdata[COORD_WIDTH-1:0])),
    .y_coord     ($signed(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
    .z_coord     ($signed(s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH])),
    .sts         (sts),
    .slope_x     (slope_x),
    .offset_x    (offset_x),
    .slope_y     (slope_y),
    .offset_y    (offset_y),
    .degenerate  (degenerate),
    .overflowed  (overflowed),
    .points_used (points_used)
  );

  // result packing
  assign m_tdata = {{(144 - 4*RES_W - CNT_W){1'b0}}, points_used,
                    offset_y, slope_y, offset_x, slope_x};
  assign m_tuser = {overflowed, degenerate};

endmodule

// ----- sv/lsf_datapath.sv -----
// Datapath: point accumulators, shared shift-add multiplier, restoring divider, result register.
module lsf_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  lsf_pkg::cmd_t                       cmd,
  input  logic signed [lsf_pkg::COORD_WIDTH-1:0] x_coord,
  input  logic signed [lsf_pkg::COORD_WIDTH-1:0] y_coord,
  input  logic signed [lsf_pkg::COORD_WIDTH-1:0] z_coord,
  output lsf_pkg::sts_t                       sts,
  output logic signed [lsf_pkg::RES_W-1:0]    slope_x,
  output logic signed [lsf_pkg::RES_W-1:0]    offset_x,
  output logic signed [lsf_pkg::RES_W-1:0]    slope_y,
  output logic signed [lsf_pkg::RES_W-1:0]    offset_y,
  output logic                                degenerate,
  output logic                                overflowed,
  output logic [lsf_pkg::CNT_W-1:0]           points_used
);
  import lsf_pkg::*;

  // accumulation state
  logic [CNT_W-1:0]                 count;
  logic                             ovf;
  logic                             pend;
  logic signed [SUM_W-1:0]          sum_z, sum_x, sum_y;
  logic signed [SQ_W-1:0]           sum_zz, sum_xz, sum_yz;
  logic signed [COORD_WIDTH-1:0]    xr, yr, zr;
  logic signed [2*COORD_WIDTH-1:0]  pzz, pxz, pyz;
  logic                             take;

  // solve state
  logic signed [OPW-1:0]   opa, opb;
  logic [OPW-1:0]          mag_a, mag_b;
  logic [PW-1:0]           ma_sh, macc;
  logic [OPW-1:0]          mb;
  logic                    mneg;
  logic signed [NUM_W-1:0] prod, pa, diff, dreg, num;
  logic [NUM_W-1:0]        nmag, dmag, rem, quo;
  logic [NUM_W:0]          r2;
  logic                    qneg;
  logic signed [RES_W-1:0] sat;
  logic signed [RES_W-1:0] res [4];
  logic [1:0]              ridx;
  logic [4:0]              sh;

  assign take = cmd.accept && (count < CNT_W'(MAX_POINTS));

  // point capture and running sums; products are registered before the add
  always_ff @(posedge clk) begin
    if (take) begin
      xr  <= x_coord;
      yr  <= y_coord;
      zr  <= z_coord;
      pzz <= z_coord * z_coord;
      pxz <= x_coord * z_coord;
      pyz <= y_coord * z_coord;
    end
    if (rst || cmd.load_out) begin
      count  <= '0;
      ovf    <= 1'b0;
      pend   <= 1'b0;
      sum_z  <= '0;
      sum_x  <= '0;
      sum_y  <= '0;
      sum_zz <= '0;
      sum_xz <= '0;
      sum_yz <= '0;
    end else begin
      pend <= take;
      if (take) count <= count + CNT_W'(1);
      if (cmd.accept && !take) ovf <= 1'b1;
      if (pend) begin
        sum_z  <= sum_z + SUM_W'(zr);
        sum_x  <= sum_x + SUM_W'(xr);
        sum_y  <= sum_y + SUM_W'(yr);
        sum_zz <= sum_zz + SQ_W'(pzz);
        sum_xz <= sum_xz + SQ_W'(pxz);
        sum_yz <= sum_yz + SQ_W'(pyz);
      end
    end
  end

  // operand and shift selection per term and half
  always_comb begin
    opa = '0;
    opb = '0;
    sh  = '0;
    case (cmd.term)
      TERM_DET: begin
        opa = cmd.half ? OPW'(sum_z) : OPW'(sum_zz);
        opb = cmd.half ? OPW'(sum_z) : OPW'($signed({1'b0, count}));
      end
      TERM_SLOPE_X: begin
        opa = cmd.half ? OPW'(sum_x) : OPW'(sum_xz);
        opb = cmd.half ? OPW'(sum_z) : OPW'($signed({1'b0, count}));
        sh  = 5'(SLOPE_SH);
      end
      TERM_OFFSET_X: begin
        opa = cmd.half ? OPW'(sum_xz) : OPW'(sum_x);
        opb = cmd.half ? OPW'(sum_z) : OPW'(sum_zz);
        sh  = 5'(OFF_SH);
      end
      TERM_SLOPE_Y: begin
        opa = cmd.half ? OPW'(sum_y) : OPW'(sum_yz);
        opb = cmd.half ? OPW'(sum_z) : OPW'($signed({1'b0, count}));
        sh  = 5'(SLOPE_SH);
      end
      TERM_OFFSET_Y: begin
        opa = cmd.half ? OPW'(sum_yz) : OPW'(sum_y);
        opb = cmd.half ? OPW'(sum_z) : OPW'(sum_zz);
        sh  = 5'(OFF_SH);
      end
      default: begin
        opa = '0;
        opb = '0;
        sh  = '0;
      end
    endcase
  end

  assign mag_a = opa[OPW-1] ? OPW'(-opa) : OPW'(opa);
  assign mag_b = opb[OPW-1] ? OPW'(-opb) : OPW'(opb);
  assign prod  = mneg ? -$signed(NUM_W'(macc)) : $signed(NUM_W'(macc));
  assign diff  = pa - prod;
  assign r2    = {rem, nmag[NUM_W-1]};
  assign ridx  = 2'(3'(cmd.term) - 3'd1);
  assign sts.d_zero = (dreg == '0);

  // saturate the truncated quotient to signed 32 bits
  always_comb begin
    if (qneg) begin
      sat = (|quo[NUM_W-1:RES_W-1]) ? {1'b1, {(RES_W-1){1'b0}}} : -$signed(quo[RES_W-1:0]);
    end else begin
      sat = (|quo[NUM_W-1:RES_W-1]) ? {1'b0, {(RES_W-1){1'b1}}} : $signed(quo[RES_W-1:0]);
    end
  end

  // multiplier, divider and result registers
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      ma_sh <= PW'(mag_a);
      mb    <= mag_b;
      macc  <= '0;
      mneg  <= opa[OPW-1] ^ opb[OPW-1];
    end
    if (cmd.mul_step) begin
      if (mb[0]) macc <= macc + ma_sh;
      ma_sh <= ma_sh << 1;
      mb    <= mb >> 1;
    end
    if (cmd.mul_done) begin
      if (!cmd.half) pa <= prod;
      else if (cmd.term == TERM_DET) dreg <= diff;
      else num <= diff <<< sh;
    end
    if (cmd.div_load) begin
      nmag <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dmag <= dreg[NUM_W-1] ? NUM_W'(-dreg) : NUM_W'(dreg);
      rem  <= '0;
      quo  <= '0;
      qneg <= num[NUM_W-1] ^ dreg[NUM_W-1];
    end
    if (cmd.div_step) begin
      nmag <= nmag << 1;
      if (r2 >= {1'b0, dmag}) begin
        rem <= NUM_W'(r2 - {1'b0, dmag});
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= r2[NUM_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd.div_store) res[ridx] <= sat;
    if (cmd.load_out) begin
      slope_x     <= sts.d_zero ? '0 : res[0];
      offset_x    <= sts.d_zero ? '0 : res[1];
      slope_y     <= sts.d_zero ? '0 : res[2];
      offset_y    <= sts.d_zero ? '0 : res[3];
      degenerate  <= sts.d_zero;
      overflowed  <= ovf;
      points_used <= count;
    end
  end

endmodule

// ----- sv/lsf_ctrl.sv -----
// Controller: point handshake, solve sequencer and output valid.
module lsf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           s_tlast,
  input  logic           m_tready,
  input  lsf_pkg::sts_t  sts,
  output logic           s_tready,
  output logic           m_tvalid,
  output lsf_pkg::cmd_t  cmd
);
  import lsf_pkg::*;

  state_t            state, state_next;
  term_t             term, term_next;
  logic              half, half_next;
  logic [ITER_W-1:0] iter, iter_next;

  // state and sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      term  <= TERM_DET;
      half  <= 1'b0;
      iter  <= '0;
    end else begin
      state <= state_next;
      term  <= term_next;
      half  <= half_next;
      iter  <= iter_next;
    end
  end

  // output valid: set on load, cleared on transfer
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.load_out) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  assign s_tready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    term_next  = term;
    half_next  = half;
    iter_next  = iter;
    cmd        = '0;
    cmd.term   = term;
    cmd.half   = half;
    cmd.accept = s_tvalid && s_tready;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tlast) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        term_next  = TERM_DET;
        half_next  = 1'b0;
        state_next = ST_MLOAD;
      end
      ST_MLOAD: begin
        cmd.mul_load = 1'b1;
        iter_next    = '0;
        state_next   = ST_MRUN;
      end
      ST_MRUN: begin
        cmd.mul_step = 1'b1;
        iter_next    = iter + ITER_W'(1);
        if (iter == ITER_W'(OPW - 1)) state_next = ST_MDONE;
      end
      ST_MDONE: begin
        cmd.mul_done = 1'b1;
        half_next    = !half;
        if (!half) state_next = ST_MLOAD;
        else if (term == TERM_DET) state_next = ST_DCHK;
        else state_next = ST_DLOAD;
      end
      ST_DCHK: begin
        if (sts.d_zero) begin
          state_next = ST_DONE;
        end else begin
          term_next  = TERM_SLOPE_X;
          state_next = ST_MLOAD;
        end
      end
      ST_DLOAD: begin
        cmd.div_load = 1'b1;
        iter_next    = '0;
        state_next   = ST_DRUN;
      end
      ST_DRUN: begin
        cmd.div_step = 1'b1;
        iter_next    = iter + ITER_W'(1);
        if (iter == ITER_W'(NUM_W - 1)) state_next = ST_DSTORE;
      end
      ST_DSTORE: begin
        cmd.div_store = 1'b1;
        if (term == TERM_OFFSET_Y) begin
          state_next = ST_DONE;
        end else begin
          term_next  = term_t'(3'(term) + 3'd1);
          state_next = ST_MLOAD;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/lsf_checker.sv -----
// Port-level checks for the line fit, bound to the top level.
module lsf_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         s_tlast,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [143:0] m_tdata,
  input logic [1:0]   m_tuser
);
  import lsf_pkg::*;

  // a held result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // degenerate fit reports zero line values
  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[127:0] == '0)
    else $error("degenerate result with nonzero line values");

  // point count never exceeds capacity
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[138:128] <= 11'(MAX_POINTS))
    else $error("points_used beyond capacity");

  // no result right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // points are refused while a solve runs
  a_solve: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("point taken during solve");

endmodule

bind least_squares_3d_line_fit lsf_checker u_chk (.*);
